// ===== rtl/orqa_pkg.sv =====
// Shared constants for the overwriting ring queue with average unit.
// Holds field widths, result and action codes, and parameter defaults.
// No dependencies.
`default_nettype none

package orqa_pkg;

  localparam int DEPTH_DEFAULT = 8;

  localparam int CAP_W     = 4;
  localparam int TAG_W     = 16;
  localparam int HEIGHT_W  = 12;
  localparam int KIND_W    = 2;
  localparam int ENTRY_W   = TAG_W + HEIGHT_W;

  localparam logic [CAP_W-1:0] CAP_RESET = 4'd5;
  localparam logic [CAP_W-1:0] CAP_MIN   = 4'd2;

  localparam logic ACT_INSERT = 1'b0;
  localparam logic ACT_REMOVE = 1'b1;

  localparam logic [KIND_W-1:0] KIND_AVERAGE = 2'd0;
  localparam logic [KIND_W-1:0] KIND_REMOVED = 2'd1;
  localparam logic [KIND_W-1:0] KIND_EMPTY   = 2'd2;

endpackage

`default_nettype wire

// ===== rtl/overwriting_ring_queue_with_average_unit.sv =====
// Ring queue of tagged heights that overwrites its oldest entry when full.
// Entries sit in one synchronous memory; the mean uses a bit-serial divider.
// Depends on orqa_pkg.
//
// A transaction is taken when start is high and busy is low; its single
// result appears for one cycle with done_o high and cannot be held off. A
// remove reads the head entry from memory and updates the queue in the
// execute state; an insert does so too, then runs the restoring divider,
// one quotient bit per cycle. The next transaction may be started in the
// cycle the result is shown. Writing the capacity empties the queue; the
// user must do it only while the block is idle, as it does not enforce this.
`default_nettype none

module overwriting_ring_queue_with_average_unit #(
  parameter int QUEUE_DEPTH = orqa_pkg::DEPTH_DEFAULT
) (
  input  wire                            clk_i,
  input  wire                            rst_ni,
  input  wire                            start,
  output logic                           busy,
  input  wire                            action_i,
  input  wire  [orqa_pkg::TAG_W-1:0]     item_tag_i,
  input  wire  [orqa_pkg::HEIGHT_W-1:0]  height_i,
  input  wire                            cfg_we_i,
  input  wire  [orqa_pkg::CAP_W-1:0]     cfg_wdata_i,
  output logic                           done_o,
  output logic [orqa_pkg::KIND_W-1:0]    result_kind_o,
  output logic [orqa_pkg::HEIGHT_W-1:0]  average_height_o,
  output logic [orqa_pkg::TAG_W-1:0]     removed_tag_o
);
  import orqa_pkg::*;

  localparam int IW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int SW = HEIGHT_W + CW;
  localparam int DW = SW + 1;
  localparam int STEP_W = $clog2(HEIGHT_W);
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(HEIGHT_W - 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_EXEC = 2'd1;
  localparam logic [1:0] ST_DIV  = 2'd2;

  logic [1:0]          state_q, state_d;
  logic [CAP_W-1:0]    cap_q;
  logic [IW-1:0]       head_q, head_d, tail_q, tail_d;
  logic [CW-1:0]       count_q, count_d;
  logic [SW-1:0]       sum_q, sum_d;
  logic                act_q;
  logic [TAG_W-1:0]    tag_in_q;
  logic [HEIGHT_W-1:0] ht_in_q;

  logic [ENTRY_W-1:0]  mem_q [QUEUE_DEPTH];
  logic [ENTRY_W-1:0]  rd_q;
  logic                mem_we;

  logic [DW-1:0]       rem_q, rem_d, dsh_q, dsh_d;
  logic [HEIGHT_W-1:0] quo_q, quo_d;
  logic [STEP_W-1:0]   step_q, step_d;

  logic                done_q, done_d;
  logic [KIND_W-1:0]   kind_q, kind_d;
  logic [HEIGHT_W-1:0] avg_q, avg_d;
  logic [TAG_W-1:0]    rtag_q, rtag_d;

  logic [CW-1:0]       cap_eff;
  logic [IW-1:0]       head_inc, tail_inc;
  logic                pop;
  logic [CW-1:0]       count_pop;
  logic [SW-1:0]       sum_pop;
  logic                ge;
  logic [DW-1:0]       diff;
  logic                accept;

  always_comb begin
    if (cap_q < CAP_MIN) begin
      cap_eff = CW'(CAP_MIN);
    end else if (32'(cap_q) > 32'(QUEUE_DEPTH)) begin
      cap_eff = CW'(QUEUE_DEPTH);
    end else begin
      cap_eff = CW'(cap_q);
    end
  end

  assign head_inc = (CW'(head_q) + CW'(1) == cap_eff) ? '0 : IW'(CW'(head_q) + CW'(1));
  assign tail_inc = (CW'(tail_q) + CW'(1) == cap_eff) ? '0 : IW'(CW'(tail_q) + CW'(1));

  assign accept = start && !busy;
  assign busy   = (state_q != ST_IDLE);

  assign pop       = (act_q == ACT_INSERT) ? (count_q >= cap_eff) : (count_q != '0);
  assign count_pop = pop ? count_q - CW'(1) : count_q;
  assign sum_pop   = pop ? sum_q - SW'(rd_q[HEIGHT_W-1:0]) : sum_q;

  assign diff = rem_q - dsh_q;
  assign ge   = (rem_q >= dsh_q);

  always_comb begin
    state_d = state_q;
    head_d  = head_q;
    tail_d  = tail_q;
    count_d = count_q;
    sum_d   = sum_q;
    mem_we  = 1'b0;
    rem_d   = rem_q;
    dsh_d   = dsh_q;
    quo_d   = quo_q;
    step_d  = step_q;
    done_d  = 1'b0;
    kind_d  = kind_q;
    avg_d   = avg_q;
    rtag_d  = rtag_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        head_d = pop ? head_inc : head_q;
        if (act_q == ACT_INSERT) begin
          mem_we  = 1'b1;
          tail_d  = tail_inc;
          count_d = count_pop + CW'(1);
          sum_d   = sum_pop + SW'(ht_in_q);
          rem_d   = {sum_d, 1'b0} + DW'(count_d);
          dsh_d   = DW'(count_d) << HEIGHT_W;
          quo_d   = '0;
          step_d  = '0;
          state_d = ST_DIV;
        end else begin
          count_d = count_pop;
          sum_d   = sum_pop;
          done_d  = 1'b1;
          avg_d   = '0;
          if (pop) begin
            kind_d = KIND_REMOVED;
            rtag_d = rd_q[ENTRY_W-1:HEIGHT_W];
          end else begin
            kind_d = KIND_EMPTY;
            rtag_d = '0;
          end
          state_d = ST_IDLE;
        end
      end
      ST_DIV: begin
        rem_d  = ge ? diff : rem_q;
        dsh_d  = dsh_q >> 1;
        quo_d  = {quo_q[HEIGHT_W-2:0], ge};
        step_d = step_q + STEP_W'(1);
        if (step_q == LAST_STEP) begin
          done_d  = 1'b1;
          kind_d  = KIND_AVERAGE;
          avg_d   = quo_d;
          rtag_d  = '0;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[tail_q] <= {tag_in_q, ht_in_q};
    end
    rd_q <= mem_q[head_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cap_q   <= CAP_RESET;
      head_q  <= '0;
      tail_q  <= '0;
      count_q <= '0;
      sum_q   <= '0;
      step_q  <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      done_q  <= done_d;
      if (cfg_we_i) begin
        cap_q   <= cfg_wdata_i;
        head_q  <= '0;
        tail_q  <= '0;
        count_q <= '0;
        sum_q   <= '0;
      end else begin
        head_q  <= head_d;
        tail_q  <= tail_d;
        count_q <= count_d;
        sum_q   <= sum_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      act_q    <= action_i;
      tag_in_q <= item_tag_i;
      ht_in_q  <= height_i;
    end
    rem_q  <= rem_d;
    dsh_q  <= dsh_d;
    quo_q  <= quo_d;
    kind_q <= kind_d;
    avg_q  <= avg_d;
    rtag_q <= rtag_d;
  end

  assign done_o           = done_q;
  assign result_kind_o    = kind_q;
  assign average_height_o = avg_q;
  assign removed_tag_o    = rtag_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(count_q) <= QUEUE_DEPTH)
    else $error("Entry count exceeds the queue depth.");

  a_sum_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(sum_q) <= 32'(count_q) * 4095)
    else $error("Height sum exceeds what the queued entries can hold.");

  a_done_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> ($past(state_q) == ST_EXEC || $past(state_q) == ST_DIV))
    else $error("Result strobe without a transaction in progress.");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (busy && state_q == ST_EXEC))
    else $error("Accepted transaction did not enter execution.");

endmodule

`default_nettype wire

// ===== bench/testbench.sv =====
// Self-checking bench for the overwriting ring queue with average unit.
// Predicts every insert average and remove result in step with the DUT.
// Depends on orqa_pkg and overwriting_ring_queue_with_average_unit.

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import orqa_pkg::*;

  localparam int DEPTH = DEPTH_DEFAULT;
  localparam int CLK_PERIOD = 8;
  localparam int RESET_CYCLES = 12;
  localparam int DRAIN_CYCLES = 40;
  localparam int CYCLE_LIMIT = 200000;
  localparam int PRINT_LIMIT = 60;

  typedef struct {
    bit                  is_cfg;
    logic [CAP_W-1:0]    capacity;
    logic                action;
    logic [TAG_W-1:0]    tag;
    logic [HEIGHT_W-1:0] height;
  } request_t;

  typedef struct packed {
    logic [KIND_W-1:0]   kind;
    logic [HEIGHT_W-1:0] average;
    logic [TAG_W-1:0]    tag;
  } outcome_t;

  typedef struct packed {
    logic [TAG_W-1:0]    tag;
    logic [HEIGHT_W-1:0] height;
  } slot_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                start = 1'b0;
  logic                action_i = ACT_INSERT;
  logic [TAG_W-1:0]    item_tag_i = '0;
  logic [HEIGHT_W-1:0] height_i = '0;
  logic                cfg_we_i = 1'b0;
  logic [CAP_W-1:0]    cfg_wdata_i = '0;
  logic                busy;
  logic                done_o;
  logic [KIND_W-1:0]   result_kind_o;
  logic [HEIGHT_W-1:0] average_height_o;
  logic [TAG_W-1:0]    removed_tag_o;

  overwriting_ring_queue_with_average_unit #(
    .QUEUE_DEPTH(DEPTH)
  ) dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .start(start),
    .busy(busy),
    .action_i(action_i),
    .item_tag_i(item_tag_i),
    .height_i(height_i),
    .cfg_we_i(cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .done_o(done_o),
    .result_kind_o(result_kind_o),
    .average_height_o(average_height_o),
    .removed_tag_o(removed_tag_o)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  request_t request_q[$];
  outcome_t pending_outcomes[$];
  int       mismatch_count = 0;
  int       cycle_count = 0;
  logic     stimulus_done = 1'b0;

  slot_t ring_copy[DEPTH];
  int    head_pos = 0;
  int    tail_pos = 0;
  int    held_count = 0;
  int    held_sum = 0;
  int    eff_capacity = int'(CAP_RESET);

  int n_averages = 0;
  int n_removed = 0;
  int n_empty = 0;
  int n_overwrites = 0;
  int n_cap_writes = 0;

  task automatic note_mismatch(input string msg);
    if (mismatch_count < PRINT_LIMIT) begin
      $display("[%0t] MISMATCH: %s", $realtime, msg);
    end
    mismatch_count++;
  endtask

  function automatic void set_capacity(input logic [CAP_W-1:0] value);
    eff_capacity = int'(value);
    if (eff_capacity < int'(CAP_MIN)) eff_capacity = int'(CAP_MIN);
    if (eff_capacity > DEPTH) eff_capacity = DEPTH;
    head_pos = 0;
    tail_pos = 0;
    held_count = 0;
    held_sum = 0;
  endfunction

  function automatic logic [TAG_W-1:0] pop_oldest();
    slot_t oldest;
    oldest = ring_copy[head_pos];
    held_sum -= int'(oldest.height);
    head_pos = (head_pos + 1) % eff_capacity;
    held_count--;
    return oldest.tag;
  endfunction

  function automatic outcome_t queue_outcome(input logic act, input logic [TAG_W-1:0] tag,
                                             input logic [HEIGHT_W-1:0] height);
    outcome_t res;
    int       mean;
    res = '0;
    if (act == ACT_INSERT) begin
      if (held_count >= eff_capacity) begin
        void'(pop_oldest());
        n_overwrites++;
      end
      ring_copy[tail_pos] = '{tag: tag, height: height};
      tail_pos = (tail_pos + 1) % eff_capacity;
      held_count++;
      held_sum += int'(height);
      mean = (2 * held_sum + held_count) / (2 * held_count);
      res.kind = KIND_AVERAGE;
      res.average = mean[HEIGHT_W-1:0];
      n_averages++;
    end else if (held_count == 0) begin
      res.kind = KIND_EMPTY;
      n_empty++;
    end else begin
      res.kind = KIND_REMOVED;
      res.tag = pop_oldest();
      n_removed++;
    end
    return res;
  endfunction

  function automatic void add_insert(input logic [TAG_W-1:0] tag,
                                     input logic [HEIGHT_W-1:0] height);
    request_q.push_back('{is_cfg: 1'b0, capacity: '0, action: ACT_INSERT, tag: tag,
                          height: height});
  endfunction

  function automatic void add_remove(input logic [TAG_W-1:0] tag,
                                     input logic [HEIGHT_W-1:0] height);
    request_q.push_back('{is_cfg: 1'b0, capacity: '0, action: ACT_REMOVE, tag: tag,
                          height: height});
  endfunction

  function automatic void add_capacity(input logic [CAP_W-1:0] value);
    request_q.push_back('{is_cfg: 1'b1, capacity: value, action: ACT_INSERT, tag: '0,
                          height: '0});
  endfunction

  bit no_gap_run = 1'b0;

  function automatic int pick_gap();
    int r;
    if ($urandom_range(0, 31) == 0) no_gap_run = !no_gap_run;
    if (no_gap_run) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 4);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [HEIGHT_W-1:0] random_height();
    int r;
    r = $urandom_range(0, 15);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return HEIGHT_W'($urandom);
  endfunction

  int in_flight = 0;
  int gap_left = 0;
  int quiet_cycles = 0;

  always @(posedge clk_i) begin : drive_requests
    request_t req;
    logic     accepted;
    logic     next_start;
    logic     next_we;
    if (rst_ni) begin
      accepted = start && !busy;
      next_start = start && !accepted;
      next_we = 1'b0;
      in_flight = in_flight + (accepted ? 1 : 0) - (done_o ? 1 : 0);
      if (in_flight == 0 && !busy && !start && !cfg_we_i) quiet_cycles++;
      else quiet_cycles = 0;
      if (!next_start) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (request_q.size() > 0) begin
          if (request_q[0].is_cfg) begin
            if (quiet_cycles >= 3) begin
              req = request_q.pop_front();
              cfg_wdata_i <= req.capacity;
              next_we = 1'b1;
              quiet_cycles = 0;
            end
          end else begin
            req = request_q.pop_front();
            action_i <= req.action;
            item_tag_i <= req.tag;
            height_i <= req.height;
            next_start = 1'b1;
            gap_left = pick_gap();
          end
        end else if (quiet_cycles >= 1) begin
          stimulus_done <= 1'b1;
        end
      end
      start <= next_start;
      cfg_we_i <= next_we;
    end
  end

  always @(posedge clk_i) begin : watch_results
    outcome_t want;
    if (rst_ni) begin
      if (done_o) begin
        if (pending_outcomes.size() == 0) begin
          note_mismatch($sformatf("result kind %0d with no transaction pending",
                                  result_kind_o));
        end else begin
          want = pending_outcomes.pop_front();
          if (result_kind_o !== want.kind)
            note_mismatch($sformatf("result_kind got %0d want %0d", result_kind_o,
                                    want.kind));
          if (average_height_o !== want.average)
            note_mismatch($sformatf("average_height got %0d want %0d", average_height_o,
                                    want.average));
          if (removed_tag_o !== want.tag)
            note_mismatch($sformatf("removed_tag got 0x%04h want 0x%04h", removed_tag_o,
                                    want.tag));
        end
      end
      if (cfg_we_i) begin
        set_capacity(cfg_wdata_i);
        n_cap_writes++;
      end
      if (start && !busy) begin
        pending_outcomes.push_back(queue_outcome(action_i, item_tag_i, height_i));
      end
    end
  end

  always @(posedge clk_i) begin : watchdog
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin : run_test
    logic [CAP_W-1:0] cap_plan[11];
    int               insert_pct;
    int               n_items;
    cap_plan = '{4'd8, 4'd2, 4'd1, 4'd9, 4'd3, 4'd7, 4'd15, 4'd4, 4'd6, 4'd0, 4'd5};

    add_remove(16'hFFFF, 12'hFFF);
    add_insert(16'hFFFF, 12'hFFF);
    add_insert(16'h0000, 12'h000);
    add_insert(16'h1234, 12'h001);
    add_insert(16'h5678, 12'h002);
    add_insert(16'h9ABC, 12'h7FF);
    add_insert(16'hDEF0, 12'h800);
    add_insert(16'hA5A5, 12'h5A5);
    add_remove(16'h0000, 12'h000);
    add_remove(16'h5A5A, 12'hA5A);
    add_capacity(4'd0);
    add_insert(16'h0001, 12'h001);
    add_insert(16'h0002, 12'h002);
    add_insert(16'h8000, 12'hFFE);
    add_remove(16'h0000, 12'h000);
    add_remove(16'h0000, 12'h000);
    add_remove(16'hFFFF, 12'hFFF);
    add_capacity(4'd15);
    for (int i = 0; i < 9; i++) add_insert(16'(16'hF000 + i), 12'hFFF);

    foreach (cap_plan[p]) begin
      add_capacity(cap_plan[p]);
      insert_pct = $urandom_range(35, 80);
      n_items = $urandom_range(32, 50);
      for (int i = 0; i < n_items; i++) begin
        if ($urandom_range(1, 100) <= insert_pct) add_insert(TAG_W'($urandom), random_height());
        else add_remove(TAG_W'($urandom), HEIGHT_W'($urandom));
      end
    end

    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;

    wait (stimulus_done);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (pending_outcomes.size() != 0) begin
      note_mismatch($sformatf("%0d results never arrived", pending_outcomes.size()));
    end

    $display("covered %0d averages, %0d removes, %0d empty removes, %0d overwrites",
             n_averages, n_removed, n_empty, n_overwrites);
    $display("over %0d capacity writes in %0d cycles, %0d mismatches", n_cap_writes,
             cycle_count, mismatch_count);
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
